// ===== rtl/ags_pkg.sv =====
// Shared types and constants for the argsort block.
// Holds the sorter cell entry, the cell control struct and the controller state.
// No dependencies.
package ags_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_WIDTH + IDX_W + 7) / 8) * 8;

    // One held element: its value and its arrival position.
    typedef struct packed {
        logic                          valid;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]              idx;
    } t_entry;

    // Per-cycle command broadcast along the cell chain.
    typedef struct packed {
        logic insert;     // place a new element into the sorted row
        logic shift_dn;   // move every entry one cell toward cell 0
        logic shift_up;   // move every entry one cell away from cell 0
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_UNLOAD
    } t_state;

endpackage

// ===== rtl/argsort_with_index.sv =====
// Unload: after block end the row is read out through the output register, from cell 0 in
// ascending order, and from the top cell in descending order once the row has shifted up to it.
// Throughput: one loaded beat per cycle while loading (s_axis_tready is low during unload);
// the unload stalls while the output sink is not ready; each beat is inserted as it is accepted.
// Reset (synchronous, active low) empties the chain, clears the count and drop flag,
// and sets descending mode.
module argsort_with_index
    import ags_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write: bit 0 is descending_mode.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_data,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,    // [31:0] sample_value
    input  logic                 s_axis_tlast,    // block_end
    // Output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,    // [31:0] sorted_value, [37:32] source_index
    output logic                 m_axis_tlast,    // run_last
    output logic [0:0]           m_axis_tuser     // [0] overflow
);

    t_state             r_state, n_state;
    logic               r_mode;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_remain, n_remain;
    logic               r_dropped, n_dropped;
    logic               r_out_valid, n_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;
    logic               r_out_ovf;

    t_cell_ctl          cell_ctl;
    t_entry             entries [DEPTH];
    logic               takes   [DEPTH];
    t_entry             exit_entry;
    logic               in_acc;
    logic               has_room;
    logic               can_step;
    logic               out_load;

    localparam t_entry EMPTY = '{valid: 1'b0, value: '0, idx: '0};

    // Configuration register: always ready; the user must write it only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data[0];
        end
    end

    // The cell chain.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry lo_entry;
        t_entry hi_entry;
        logic   lo_take;

        if (k == 0) begin : g_first
            assign lo_entry = EMPTY;
            assign lo_take  = 1'b0;
        end else begin : g_mid_lo
            assign lo_entry = entries[k-1];
            assign lo_take  = takes[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign hi_entry = EMPTY;
        end else begin : g_mid_hi
            assign hi_entry = entries[k+1];
        end

        ags_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_new_value (s_axis_tdata[VALUE_WIDTH-1:0]),
            .i_new_idx   (r_count[IDX_W-1:0]),
            .i_lo        (lo_entry),
            .i_hi        (hi_entry),
            .i_lo_take   (lo_take),
            .o_take      (takes[k]),
            .o_entry     (entries[k])
        );
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_acc        = s_axis_tvalid && (r_state == ST_LOAD);
    assign has_room      = (r_count < CNT_W'(DEPTH));
    assign can_step      = !r_out_valid || m_axis_tready;

    // Ascending order leaves from cell 0, descending order from the top cell.
    assign exit_entry = r_mode ? entries[DEPTH-1] : entries[0];

    // Next state, counters and chain commands.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_remain  = r_remain;
        n_dropped = r_dropped;
        cell_ctl  = '0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (has_room) begin
                        cell_ctl.insert = 1'b1;
                        n_count         = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_remain = has_room ? r_count + CNT_W'(1) : r_count;
                        n_state  = ST_UNLOAD;
                    end
                end
            end
            ST_UNLOAD: begin
                if (can_step) begin
                    cell_ctl.shift_dn = !r_mode;
                    cell_ctl.shift_up = r_mode;
                    if (exit_entry.valid) begin
                        out_load = 1'b1;
                        n_remain = r_remain - CNT_W'(1);
                        if (r_remain == CNT_W'(1)) begin
                            n_state   = ST_LOAD;
                            n_count   = '0;
                            n_dropped = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_remain  <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_remain  <= n_remain;
            r_dropped <= n_dropped;
        end
    end

    // Output register: holds one beat until the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= exit_entry.value;
            r_out_idx   <= exit_entry.idx;
            r_out_last  <= (r_remain == CNT_W'(1));
            r_out_ovf   <= r_dropped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - VALUE_WIDTH - IDX_W){1'b0}}, r_out_idx, r_out_value};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

endmodule

// ===== rtl/ags_cell.sv =====
// One cell of the insertion-sort chain: holds a single entry.
// Depends on ags_pkg for the entry and control types.
// The row is kept in ascending (value, index) order from cell 0 up.
module ags_cell
    import ags_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_new_value,
    input  logic [IDX_W-1:0]              i_new_idx,
    input  t_entry                        i_lo,         // entry of the cell below
    input  t_entry                        i_hi,         // entry of the cell above
    input  logic                          i_lo_take,    // cell below also moves up
    output logic                          o_take,
    output t_entry                        o_entry
);

    logic                          r_valid;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic [IDX_W-1:0]              r_idx;
    t_entry                        n_entry;

    // The new element arrives last, so on an equal value it goes above.
    assign o_take = !r_valid || (i_new_value < r_value);

    // Next entry: insert, shift, or hold.
    always_comb begin
        n_entry = '{valid: r_valid, value: r_value, idx: r_idx};
        priority if (i_ctl.insert) begin
            if (o_take) begin
                if (i_lo_take) begin
                    n_entry = i_lo;
                end else begin
                    n_entry = '{valid: 1'b1, value: i_new_value, idx: i_new_idx};
                end
            end
        end else if (i_ctl.shift_dn) begin
            n_entry = i_hi;
        end else if (i_ctl.shift_up) begin
            n_entry = i_lo;
        end else begin
            n_entry = '{valid: r_valid, value: r_value, idx: r_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_entry.value;
        r_idx   <= n_entry.idx;
    end

    assign o_entry = '{valid: r_valid, value: r_value, idx: r_idx};

endmodule
